@@ design/cal_pkg.sv @@
// Shared constants, codes and types for the cursor array list.
`timescale 1ns / 1ps

package cal_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;

    // result beat: cursor_value, cursor_index, item_count, found, status
    localparam int RES_W       = DATA_W + IDX_W + CNT_W + 1 + STAT_W;
    localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_NEXT   = 3'd2,
        OP_BACK   = 3'd3,
        OP_START  = 3'd4,
        OP_END    = 3'd5,
        OP_UPDATE = 3'd6,
        OP_FIND   = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BOUNDARY = 2'd3
    } status_t;

    // what every cell does this cycle, relative to pos
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,  // keep contents
        CELL_LOAD  = 2'd1,  // cell at pos takes the input word
        CELL_SHR   = 2'd2,  // cells above pos take left neighbor, pos takes input word
        CELL_SHL   = 2'd3   // cells at and above pos take right neighbor
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
    } cell_cmd_t;

endpackage

@@ design/cal_cell.sv @@
// One storage cell of the list: holds a word, shifts with its neighbors, compares.
`timescale 1ns / 1ps

module cal_cell
(
    input  logic                        clk,
    input  logic                        accept,
    input  logic [cal_pkg::IDX_W-1:0]   idx,
    input  cal_pkg::cell_cmd_t          cmd,
    input  logic [cal_pkg::DATA_W-1:0]  value,
    input  logic [cal_pkg::DATA_W-1:0]  left_data,
    input  logic [cal_pkg::DATA_W-1:0]  right_data,
    input  logic [cal_pkg::CNT_W-1:0]   count,
    output logic [cal_pkg::DATA_W-1:0]  data,
    output logic [cal_pkg::DATA_W-1:0]  data_next,
    output logic                        hit
);

    logic [cal_pkg::DATA_W-1:0] data_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            cal_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            cal_pkg::CELL_LOAD:
            begin
                if (idx == cmd.pos)
                    data_next = value;
            end
            cal_pkg::CELL_SHR:
            begin
                if (idx == cmd.pos)
                    data_next = value;
                else if (idx > cmd.pos)
                    data_next = left_data;
            end
            cal_pkg::CELL_SHL:
            begin
                if (idx >= cmd.pos)
                    data_next = right_data;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_next;
    end

    // only occupied cells may match
    assign hit  = (data_reg == value) && (cal_pkg::CNT_W'(idx) < count);
    assign data = data_reg;

endmodule

@@ design/cal_ctrl.sv @@
// Cursor and count registers, operation decode and status for the list.
`timescale 1ns / 1ps

module cal_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  cal_pkg::op_t               op,
    output logic [cal_pkg::IDX_W-1:0]  cursor,
    output logic [cal_pkg::CNT_W-1:0]  count,
    output logic [cal_pkg::IDX_W-1:0]  cursor_next,
    output logic [cal_pkg::CNT_W-1:0]  count_next,
    output cal_pkg::status_t           status,
    output cal_pkg::cell_cmd_t         cmd
);

    logic [cal_pkg::IDX_W-1:0] cursor_reg;
    logic [cal_pkg::CNT_W-1:0] count_reg;
    logic                      empty;
    logic                      full;
    logic                      at_last;
    logic [cal_pkg::IDX_W-1:0] last_idx;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= cal_pkg::CNT_W'(cal_pkg::CAPACITY));
    assign at_last  = (cal_pkg::CNT_W'(cursor_reg) + cal_pkg::CNT_W'(1)) >= count_reg;
    assign last_idx = cal_pkg::IDX_W'(count_reg - cal_pkg::CNT_W'(1));

    always_comb
    begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        status      = cal_pkg::ST_OK;
        cmd.op      = cal_pkg::CELL_HOLD;
        cmd.pos     = cursor_reg;
        unique case (op)
            cal_pkg::OP_INSERT:
            begin
                if (full)
                    status = cal_pkg::ST_FULL;
                else if (empty)
                begin
                    cmd.op      = cal_pkg::CELL_LOAD;
                    cmd.pos     = '0;
                    cursor_next = '0;
                    count_next  = cal_pkg::CNT_W'(1);
                end
                else
                begin
                    // cursor <= count-1 <= CAPACITY-2 here, so +1 fits
                    cmd.op      = cal_pkg::CELL_SHR;
                    cmd.pos     = cursor_reg + cal_pkg::IDX_W'(1);
                    cursor_next = cursor_reg + cal_pkg::IDX_W'(1);
                    count_next  = count_reg + cal_pkg::CNT_W'(1);
                end
            end
            cal_pkg::OP_REMOVE:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else
                begin
                    cmd.op     = cal_pkg::CELL_SHL;
                    count_next = count_reg - cal_pkg::CNT_W'(1);
                    if (cursor_reg != '0)
                        cursor_next = cursor_reg - cal_pkg::IDX_W'(1);
                end
            end
            cal_pkg::OP_NEXT:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else if (at_last)
                    status = cal_pkg::ST_BOUNDARY;
                else
                    cursor_next = cursor_reg + cal_pkg::IDX_W'(1);
            end
            cal_pkg::OP_BACK:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else if (cursor_reg == '0)
                    status = cal_pkg::ST_BOUNDARY;
                else
                    cursor_next = cursor_reg - cal_pkg::IDX_W'(1);
            end
            cal_pkg::OP_START:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else
                    cursor_next = '0;
            end
            cal_pkg::OP_END:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else
                    cursor_next = last_idx;
            end
            cal_pkg::OP_UPDATE:
            begin
                if (empty)
                    status = cal_pkg::ST_EMPTY;
                else
                    cmd.op = cal_pkg::CELL_LOAD;
            end
            cal_pkg::OP_FIND:
            begin
                status = cal_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    assign cursor = cursor_reg;
    assign count  = count_reg;

endmodule

@@ design/cursor_array_list_top.sv @@
// Cursor array list: row of storage cells, cursor control and result register.
// Result: the result beat appears in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while results are taken; all cells shift,
// load or compare in the same cycle; the result register frees when it is taken.
// Reset: count, cursor and result valid clear; stored words are not cleared.
`timescale 1ns / 1ps

module cursor_array_list_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cal_pkg::DATA_W-1:0]        s_axis_tdata,  // value
    input  logic [cal_pkg::OP_W-1:0]          s_axis_tuser,  // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cursor_value, cursor_index, item_count, found, status, zero pad
    output logic [cal_pkg::RES_TDATA_W-1:0]   m_axis_tdata
);

    logic                              accept;
    cal_pkg::op_t                      op;
    logic [cal_pkg::IDX_W-1:0]         cursor;
    logic [cal_pkg::CNT_W-1:0]         count;
    logic [cal_pkg::IDX_W-1:0]         cursor_next;
    logic [cal_pkg::CNT_W-1:0]         count_next;
    cal_pkg::status_t                  status;
    cal_pkg::cell_cmd_t                cmd;

    logic [cal_pkg::DATA_W-1:0]        cell_data [cal_pkg::CAPACITY];
    logic [cal_pkg::DATA_W-1:0]        cell_next [cal_pkg::CAPACITY];
    logic [cal_pkg::DATA_W-1:0]        cell_left [cal_pkg::CAPACITY];
    logic [cal_pkg::DATA_W-1:0]        cell_right[cal_pkg::CAPACITY];
    logic [cal_pkg::CAPACITY-1:0]      hit;

    logic [cal_pkg::DATA_W-1:0]        cursor_value;
    logic                              found;

    logic                              out_valid_reg;
    logic [cal_pkg::RES_TDATA_W-1:0]   out_data_reg;

    assign op            = cal_pkg::op_t'(s_axis_tuser);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cal_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .cursor      (cursor),
        .count       (count),
        .cursor_next (cursor_next),
        .count_next  (count_next),
        .status      (status),
        .cmd         (cmd)
    );

    genvar gi;
    generate
        for (gi = 0; gi < cal_pkg::CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign cell_left[gi] = cell_data[gi];
            end
            else
            begin : g_mid_l
                assign cell_left[gi] = cell_data[gi-1];
            end

            if (gi == cal_pkg::CAPACITY - 1)
            begin : g_last
                assign cell_right[gi] = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign cell_right[gi] = cell_data[gi+1];
            end

            cal_cell u_cell
            (
                .clk        (clk),
                .accept     (accept),
                .idx        (cal_pkg::IDX_W'(gi)),
                .cmd        (cmd),
                .value      (s_axis_tdata),
                .left_data  (cell_left[gi]),
                .right_data (cell_right[gi]),
                .count      (count),
                .data       (cell_data[gi]),
                .data_next  (cell_next[gi]),
                .hit        (hit[gi])
            );
        end
    endgenerate

    assign cursor_value = (count_next == '0) ? '0 : cell_next[cursor_next];
    assign found        = (op == cal_pkg::OP_FIND) && (|hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= cal_pkg::RES_TDATA_W'({status, found, count_next,
                                                   cursor_next, cursor_value});
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count <= cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        else $error("item count above capacity");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (count == '0) ? (cursor == '0) : (cal_pkg::CNT_W'(cursor) < count))
        else $error("cursor outside stored items");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == cal_pkg::OP_INSERT &&
         count == cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        |=> ($stable(count) && $stable(cursor)))
        else $error("insert into full list changed state");
`endif

endmodule
